>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the timer queue");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the timer queue");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/dtq_pkg.sv
package dtq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_DELAY_BITS  = 16;
    localparam int IN_DELAY_BITS   = 16;
    localparam int ID_BITS         = 8;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_BITS        = $clog2(MAX_RESULTS);

    typedef enum logic
    {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } state_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed
    {
        logic insert;
        logic decr;
        logic pop;
    } cmd_t;

    // Status of the front and back of the chain, seen by the controller.
    typedef struct packed
    {
        logic head_valid;
        logic head_zero;
        logic next_zero;
        logic full;
    } status_t;

endpackage

>>> sv/dtq_cell.sv
module dtq_cell #(
    parameter int DELAY_BITS = dtq_pkg::DEF_DELAY_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dtq_pkg::cmd_t                cmd,
    input  logic [DELAY_BITS-1:0]        new_rem,
    input  logic [dtq_pkg::ID_BITS-1:0]  new_id,
    input  logic                         new_flag,
    input  logic                         left_valid,
    input  logic                         left_gt,
    input  logic [DELAY_BITS-1:0]        left_rem,
    input  logic [dtq_pkg::ID_BITS-1:0]  left_id,
    input  logic                         left_flag,
    input  logic                         right_valid,
    input  logic [DELAY_BITS-1:0]        right_rem,
    input  logic [dtq_pkg::ID_BITS-1:0]  right_id,
    input  logic                         right_flag,
    output logic                         valid,
    output logic                         gt,
    output logic [DELAY_BITS-1:0]        rem,
    output logic [dtq_pkg::ID_BITS-1:0]  id,
    output logic                         flag
);

    // Each cell keeps the ticks remaining until its own expiry. The chain is
    // kept sorted, so the cells that expire later than a new entry form a tail.
    logic                        valid_reg, valid_next;
    logic [DELAY_BITS-1:0]       rem_reg, rem_next;
    logic [dtq_pkg::ID_BITS-1:0] id_reg, id_next;
    logic                        flag_reg, flag_next;

    assign gt = valid_reg && (rem_reg > new_rem);

    always_comb
    begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        id_next    = id_reg;
        flag_next  = flag_reg;
        if (cmd.insert)
        begin
            if (left_gt)
            begin
                valid_next = 1'b1;
                rem_next   = left_rem;
                id_next    = left_id;
                flag_next  = left_flag;
            end
            else if (gt || (left_valid && !valid_reg))
            begin
                valid_next = 1'b1;
                rem_next   = new_rem;
                id_next    = new_id;
                flag_next  = new_flag;
            end
        end
        else if (cmd.decr)
        begin
            if (valid_reg)
            begin
                rem_next = rem_reg - DELAY_BITS'(1);
            end
        end
        else if (cmd.pop)
        begin
            valid_next = right_valid;
            rem_next   = right_rem;
            id_next    = right_id;
            flag_next  = right_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        id_reg   <= id_next;
        flag_reg <= flag_next;
    end

    assign valid = valid_reg;
    assign rem   = rem_reg;
    assign id    = id_reg;
    assign flag  = flag_reg;

endmodule

>>> sv/dtq_ctrl.sv
module dtq_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         operation,
    input  dtq_pkg::status_t             status,
    input  logic [dtq_pkg::ID_BITS-1:0]  head_id,
    input  logic                         head_flag,
    output logic                         busy,
    output dtq_pkg::cmd_t                cmd,
    output logic                         result_valid,
    output logic [1:0]                   kind,
    output logic [dtq_pkg::ID_BITS-1:0]  expired_id,
    output logic                         expired_important,
    output logic                         last
);

    dtq_pkg::state_t               state_reg, state_next;
    logic [dtq_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                          res_valid_reg, res_valid_next;
    dtq_pkg::kind_t                kind_reg, kind_next;
    logic [dtq_pkg::ID_BITS-1:0]   id_reg, id_next;
    logic                          imp_reg, imp_next;
    logic                          last_reg, last_next;
    logic                          pop_last;

    // The pop that hits the per-tick limit ends the tick even if more
    // entries are due; they go out on the next tick.
    assign pop_last = !status.next_zero
                      || (cnt_reg == dtq_pkg::CNT_BITS'(dtq_pkg::MAX_RESULTS - 1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        res_valid_next = 1'b0;
        kind_next      = kind_reg;
        id_next        = id_reg;
        imp_next       = imp_reg;
        last_next      = last_reg;
        unique case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (dtq_pkg::op_t'(operation) == dtq_pkg::OP_ADD)
                    begin
                        res_valid_next = 1'b1;
                        id_next        = '0;
                        imp_next       = 1'b0;
                        last_next      = 1'b1;
                        if (status.full)
                        begin
                            kind_next = dtq_pkg::KIND_REJECTED;
                        end
                        else
                        begin
                            kind_next  = dtq_pkg::KIND_ACCEPTED;
                            cmd.insert = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.decr   = status.head_valid && !status.head_zero;
                        cnt_next   = '0;
                        state_next = dtq_pkg::ST_POP;
                    end
                end
            end
            dtq_pkg::ST_POP:
            begin
                if (status.head_valid && status.head_zero)
                begin
                    cmd.pop        = 1'b1;
                    res_valid_next = 1'b1;
                    kind_next      = dtq_pkg::KIND_EXPIRED;
                    id_next        = head_id;
                    imp_next       = head_flag;
                    last_next      = pop_last;
                    cnt_next       = cnt_reg + dtq_pkg::CNT_BITS'(1);
                    if (pop_last)
                    begin
                        state_next = dtq_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtq_pkg::ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        imp_reg  <= imp_next;
        last_reg <= last_next;
    end

    assign busy              = (state_reg == dtq_pkg::ST_POP);
    assign result_valid      = res_valid_reg;
    assign kind              = kind_reg;
    assign expired_id        = id_reg;
    assign expired_important = imp_reg;
    assign last              = last_reg;

endmodule

>>> sv/delta_timer_queue.sv
// An add request gives its single result in the cycle after it is accepted.
// A new request can follow an add directly; a tick holds busy until its pop phase ends.
// The tick rate is set by the head cell: the chain shifts out one entry per cycle.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result.
// Results are strobed for one cycle each; the receiver cannot stall them.
// A tick pops at most 16 entries; entries still due go out on the next tick.
`include "assert_macros.svh"

module delta_timer_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
    parameter int DELAY_BITS  = dtq_pkg::DEF_DELAY_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [dtq_pkg::IN_DELAY_BITS-1:0]   delay_ticks,
    input  logic [dtq_pkg::ID_BITS-1:0]         task_id,
    input  logic                                important,
    output logic                                result_valid,
    output logic [1:0]                          kind,
    output logic [dtq_pkg::ID_BITS-1:0]         expired_id,
    output logic                                expired_important,
    output logic                                last
);

    // The queue is a row of cells, head in cell 0. Rather than the relative
    // delays of a delta list, every cell holds the absolute ticks that remain
    // until its entry expires. The two forms give the same order and the same
    // expiries: a tick that lowers the head delta lowers every remaining count,
    // and an entry with a zero delta behind the head has a zero count too.
    //
    // In an add request, every cell compares its count with the new delay at
    // once, the cells that expire strictly later shift one place toward the
    // tail, and the first free or later cell takes the new entry, so ties land
    // behind existing entries.
    //
    // A tick request first lowers all counts by one unless the head is already
    // at zero, which happens when the previous tick hit its expiry limit. Then
    // the controller pops a zero head once per cycle, up to the expiry limit.

    localparam int WIDE_BITS = (DELAY_BITS > dtq_pkg::IN_DELAY_BITS)
                               ? DELAY_BITS : dtq_pkg::IN_DELAY_BITS;
    localparam logic [WIDE_BITS-1:0] DELAY_MAX =
        WIDE_BITS'((65'd1 << DELAY_BITS) - 65'd1);

    logic [WIDE_BITS-1:0]        delay_wide;
    logic [DELAY_BITS-1:0]       new_rem;

    logic [QUEUE_DEPTH-1:0]      valid_vec;
    logic [QUEUE_DEPTH-1:0]      gt_vec;
    logic [DELAY_BITS-1:0]       rem_arr  [QUEUE_DEPTH];
    logic [dtq_pkg::ID_BITS-1:0] id_arr   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      flag_vec;

    dtq_pkg::cmd_t               cmd;
    dtq_pkg::status_t            status;

    // A zero delay counts as one tick; a delay wider than the counters
    // saturates at their largest value.
    always_comb
    begin
        delay_wide = WIDE_BITS'(delay_ticks);
        if (delay_ticks == '0)
        begin
            delay_wide = WIDE_BITS'(1);
        end
        if (delay_wide > DELAY_MAX)
        begin
            delay_wide = DELAY_MAX;
        end
    end

    assign new_rem = delay_wide[DELAY_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                        lv, lg, lf, rv, rf;
            logic [DELAY_BITS-1:0]       lr, rr;
            logic [dtq_pkg::ID_BITS-1:0] li, ri;

            if (gi == 0)
            begin : g_head
                // The head sees a virtual occupied neighbor that never shifts.
                assign lv = 1'b1;
                assign lg = 1'b0;
                assign lr = '0;
                assign li = '0;
                assign lf = 1'b0;
            end
            else
            begin : g_body
                assign lv = valid_vec[gi-1];
                assign lg = gt_vec[gi-1];
                assign lr = rem_arr[gi-1];
                assign li = id_arr[gi-1];
                assign lf = flag_vec[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign rv = 1'b0;
                assign rr = '0;
                assign ri = '0;
                assign rf = 1'b0;
            end
            else
            begin : g_inner
                assign rv = valid_vec[gi+1];
                assign rr = rem_arr[gi+1];
                assign ri = id_arr[gi+1];
                assign rf = flag_vec[gi+1];
            end

            dtq_cell #(
                .DELAY_BITS (DELAY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .new_rem     (new_rem),
                .new_id      (task_id),
                .new_flag    (important),
                .left_valid  (lv),
                .left_gt     (lg),
                .left_rem    (lr),
                .left_id     (li),
                .left_flag   (lf),
                .right_valid (rv),
                .right_rem   (rr),
                .right_id    (ri),
                .right_flag  (rf),
                .valid       (valid_vec[gi]),
                .gt          (gt_vec[gi]),
                .rem         (rem_arr[gi]),
                .id          (id_arr[gi]),
                .flag        (flag_vec[gi])
            );
        end
    endgenerate

    assign status.head_valid = valid_vec[0];
    assign status.head_zero  = (rem_arr[0] == '0);
    assign status.next_zero  = valid_vec[1] && (rem_arr[1] == '0);
    assign status.full       = valid_vec[QUEUE_DEPTH-1];

    dtq_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .operation         (operation),
        .status            (status),
        .head_id           (id_arr[0]),
        .head_flag         (flag_vec[0]),
        .busy              (busy),
        .cmd               (cmd),
        .result_valid      (result_valid),
        .kind              (kind),
        .expired_id        (expired_id),
        .expired_important (expired_important),
        .last              (last)
    );

    // Occupied cells always form one run from the head.
    `ASSERT_SAME(a_packed_chain, clk, rst_n, 1'b1, ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    // A full chain never takes a new entry.
    `ASSERT_SAME(a_no_insert_full, clk, rst_n, cmd.insert, !status.full)
    // An accepted tick always enters the pop phase.
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, start && !busy && operation, busy)
    // An expiry that is not the last of its tick leaves the pop phase running.
    `ASSERT_SAME(a_pop_continues, clk, rst_n,
        result_valid && (kind == dtq_pkg::KIND_EXPIRED) && !last, busy)

endmodule

>>> verif/delta_timer_queue_tb.sv
`timescale 1ns / 100ps

module delta_timer_queue_tb;

    localparam int DEPTH      = dtq_pkg::DEF_QUEUE_DEPTH;
    localparam int DBITS      = dtq_pkg::DEF_DELAY_BITS;
    localparam longint DELAY_CEIL = (longint'(1) << DBITS) - 1;

    // One request as the driver presents it to the block.
    typedef struct
    {
        dtq_pkg::op_t                      op;
        logic [dtq_pkg::IN_DELAY_BITS-1:0] delay;
        logic [dtq_pkg::ID_BITS-1:0]       id;
        logic                              imp;
    } timer_request_t;

    // One result as the block should strobe it out.
    typedef struct
    {
        dtq_pkg::kind_t              kind;
        logic [dtq_pkg::ID_BITS-1:0] id;
        logic                        imp;
        logic                        last;
    } timer_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              operation = 1'b0;
    logic [dtq_pkg::IN_DELAY_BITS-1:0] delay_ticks = '0;
    logic [dtq_pkg::ID_BITS-1:0]       task_id = '0;
    logic                              important = 1'b0;
    logic                              busy;
    logic                              result_valid;
    logic [1:0]                        kind;
    logic [dtq_pkg::ID_BITS-1:0]       expired_id;
    logic                              expired_important;
    logic                              last;

    // Requests still to be sent, and results the block still owes us.
    timer_request_t pending_requests[$];
    timer_result_t  due_results[$];

    // Our own copy of the delta list: head at index 0, each delta relative to
    // the entry ahead of it.
    longint                      queue_delta[DEPTH];
    logic [dtq_pkg::ID_BITS-1:0] queue_id[DEPTH];
    logic                        queue_flag[DEPTH];
    int                          queue_fill = 0;

    int mismatches = 0;
    int idle_left  = 0;
    int idle_pct   = 20;
    int accepted   = 0;

    delta_timer_queue u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .delay_ticks       (delay_ticks),
        .task_id           (task_id),
        .important         (important),
        .result_valid      (result_valid),
        .kind              (kind),
        .expired_id        (expired_id),
        .expired_important (expired_important),
        .last              (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one accepted request to the delta list and queues the results
    // it causes.
    function automatic void advance_timer_list(dtq_pkg::op_t op,
                                               logic [dtq_pkg::IN_DELAY_BITS-1:0] delay,
                                               logic [dtq_pkg::ID_BITS-1:0] id,
                                               logic imp);
        longint        want_delay;
        longint        sum;
        int            pos;
        int            popped;
        timer_result_t res;

        if (op == dtq_pkg::OP_ADD)
        begin
            want_delay = longint'(delay);
            // A zero delay still fires on the next tick.
            if (want_delay == 0)
                want_delay = 1;
            if (want_delay > DELAY_CEIL)
                want_delay = DELAY_CEIL;
            res = '{kind: dtq_pkg::KIND_ACCEPTED, id: '0, imp: 1'b0, last: 1'b1};
            if (queue_fill >= DEPTH)
            begin
                // A full list turns the request away and keeps its contents.
                res.kind = dtq_pkg::KIND_REJECTED;
                due_results.push_back(res);
                return;
            end
            // Walk forward to the first entry that expires strictly later;
            // entries with an equal expiry stay ahead of the new one.
            sum = 0;
            for (pos = 0; pos < queue_fill; pos++)
            begin
                if (sum + queue_delta[pos] > want_delay)
                    break;
                sum += queue_delta[pos];
            end
            if (pos < queue_fill)
                queue_delta[pos] = sum + queue_delta[pos] - want_delay;
            for (int i = queue_fill; i > pos; i--)
            begin
                queue_delta[i] = queue_delta[i - 1];
                queue_id[i]    = queue_id[i - 1];
                queue_flag[i]  = queue_flag[i - 1];
            end
            queue_delta[pos] = want_delay - sum;
            queue_id[pos]    = id;
            queue_flag[pos]  = imp;
            queue_fill++;
            due_results.push_back(res);
        end
        else
        begin
            // A tick on an empty list does nothing at all.
            if (queue_fill == 0)
                return;
            // A head left at zero by a capped tick is popped without counting.
            if (queue_delta[0] != 0)
                queue_delta[0]--;
            if (queue_delta[0] != 0)
                return;
            popped = 0;
            while (queue_fill > 0 && queue_delta[0] == 0 && popped < dtq_pkg::MAX_RESULTS)
            begin
                res = '{kind: dtq_pkg::KIND_EXPIRED, id: queue_id[0], imp: queue_flag[0],
                        last: 1'b0};
                due_results.push_back(res);
                for (int i = 1; i < queue_fill; i++)
                begin
                    queue_delta[i - 1] = queue_delta[i];
                    queue_id[i - 1]    = queue_id[i];
                    queue_flag[i - 1]  = queue_flag[i];
                end
                queue_fill--;
                popped++;
            end
            due_results[due_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void note_mismatch(string msg);
        if (mismatches < 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endfunction

    // Driver: presents the oldest pending request until the block takes it.
    // Idle bursts are dropped in at random, with their rate changing every
    // few dozen requests so that some stretches have none; the last requests
    // go in back to back.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                void'(pending_requests.pop_front());
                accepted++;
                if (accepted % 30 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 20;
                        default: idle_pct = 50;
                    endcase
                end
            end
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 25 && $urandom_range(0, 99) < idle_pct)
            begin
                // This cycle is the first of the burst.
                idle_left = $urandom_range(0, 8);
                start <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                start       <= 1'b1;
                operation   <= pending_requests[0].op;
                delay_ticks <= pending_requests[0].delay;
                task_id     <= pending_requests[0].id;
                important   <= pending_requests[0].imp;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predicts from the request the block takes at this edge, then
    // checks any result strobed in the cycle that this edge ends. Both read
    // only values from before the edge, so the order against the driver does
    // not matter.
    always @(posedge clk)
    begin : monitor
        timer_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                advance_timer_list(dtq_pkg::op_t'(operation), delay_ticks, task_id,
                                   important);
            if (result_valid)
            begin
                if (due_results.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result kind=%0d id=%02h imp=%0b last=%0b",
                                            kind, expired_id, expired_important, last));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (kind !== want.kind || expired_id !== want.id ||
                        expired_important !== want.imp || last !== want.last)
                        note_mismatch($sformatf({"expected kind=%0d id=%02h imp=%0b last=%0b,",
                                                 " got kind=%0d id=%02h imp=%0b last=%0b"},
                                                want.kind, want.id, want.imp, want.last,
                                                kind, expired_id, expired_important, last));
                end
            end
        end
    end

    task automatic queue_add(int delay, int id, int imp);
        timer_request_t req;
        req = '{op: dtq_pkg::OP_ADD, delay: delay[dtq_pkg::IN_DELAY_BITS-1:0],
                id: id[dtq_pkg::ID_BITS-1:0], imp: imp[0]};
        pending_requests.push_back(req);
    endtask

    // Tick requests carry random junk in the fields the block ignores.
    task automatic queue_tick();
        timer_request_t req;
        req = '{op: dtq_pkg::OP_TICK, delay: dtq_pkg::IN_DELAY_BITS'($urandom),
                id: dtq_pkg::ID_BITS'($urandom), imp: 1'($urandom)};
        pending_requests.push_back(req);
    endtask

    initial
    begin : stimulus
        int made;
        int burst;
        int pick;
        int delay;

        // Directed part. A tick on an empty list, then a zero delay that must
        // act as one tick, with ties on equal expiries kept in arrival order.
        queue_tick();
        queue_add(0, 8'h00, 0);
        queue_add(1, 8'hFF, 1);
        queue_add(2, 8'h5A, 0);
        queue_add(2, 8'h3C, 1);
        queue_tick();
        queue_tick();
        // Fill the list with sixteen equal delays, get turned away with the
        // widest delay, then see one tick with no expiry and one that drains
        // all sixteen entries in a single burst.
        for (int i = 0; i < DEPTH; i++)
            queue_add(2, 8'h10 + i, i % 2);
        queue_add(16'hFFFF, 8'hC3, 1);
        queue_tick();
        queue_tick();
        // The widest delay accepted; it sits at the tail for the rest of the run.
        queue_add(16'hFFFF, 8'hA5, 1);

        // Random part: bursts of adds followed by bursts of ticks, so the
        // list fills up, gets rejections and expires in groups of ties.
        made = 0;
        while (made < 90)
        begin
            burst = $urandom_range(1, 7);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    delay = 0;
                else if (pick < 12)
                    delay = $urandom_range(13, 60);
                else
                    delay = $urandom_range(1, 12);
                queue_add(delay, $urandom_range(0, 255), $urandom_range(0, 1));
                made++;
            end
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                queue_tick();
                made++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        // Leave room for any stray results.
        repeat (40) @(posedge clk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
